>>> sv/bhe_pkg.sv
// bhe_pkg: shared types and constants for the binary heap engine
// no dependencies
package bhe_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W = 32;
    localparam int FUNC_W = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W = 5;

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_XMIN   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_XMAX   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_BMIN   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_BMAX   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [VALUE_W-1:0] value;
    } bhe_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic [STATUS_W-1:0]       status;
        logic [FILL_W-1:0]         fill_count;
    } bhe_out_t;

endpackage

>>> sv/binary_heap_engine.sv
// binary_heap_engine: array heap with append, insert, extract and build operations
// depends on bhe_pkg
//
// channel  | dir | payload   | handshake
// in       | in  | bhe_in_t  | in_valid / in_stall
// out      | out | bhe_out_t | out_valid / out_stall
//
// one item at a time; the heap memory has one read per cycle and its data is registered
// append, reject, no-op or build on fewer than two entries: straight from S_IDLE to S_OUT
// insert: S_URD and S_UCMP per level climbed; extract: S_DLAST, then a sift-down
// build: a load, a sift-down and a write-back per internal node
// reset clears the count and the control only; the memory is not cleared
// in_stall is high while an item is in progress; a stalled result holds the engine in S_OUT
module binary_heap_engine #(
    parameter int DEPTH = bhe_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bhe_pkg::bhe_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output bhe_pkg::bhe_out_t out_data
);
    import bhe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = AW + 2;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_URD   = 11'b00000000010,
        S_UCMP  = 11'b00000000100,
        S_DLAST = 11'b00000001000,
        S_DLOAD = 11'b00000010000,
        S_DPOS  = 11'b00000100000,
        S_DLEFT = 11'b00001000000,
        S_DRGT  = 11'b00010000000,
        S_DEND  = 11'b00100000000,
        S_DSWP  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic we;
    logic [AW-1:0] wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] child_reg, child_next;
    logic [PW-1:0] bi_reg, bi_next;
    logic is_max_reg, is_max_next;
    logic tie_r_reg, tie_r_next;
    logic build_reg, build_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] pv_reg, pv_next;
    logic signed [VALUE_W-1:0] cv_reg, cv_next;
    logic signed [VALUE_W-1:0] top_reg, top_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic out_valid_reg, out_valid_next;
    bhe_out_t out_reg, out_next;

    logic [PW-1:0] parent;
    logic [PW-1:0] rgt;
    logic [PW-1:0] b_start;
    logic [PW-1:0] bi_dec;
    logic take_r, move;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign parent = (pos_reg - PW'(1)) >> 1;
    assign rgt = child_reg + PW'(1);
    assign b_start = PW'((cnt_reg - CW'(2)) >> 1);
    assign bi_dec = bi_reg - PW'(1);
    assign take_r = (is_max_reg ? (rd_reg > cv_reg) : (rd_reg < cv_reg))
                    || (tie_r_reg && rd_reg == cv_reg);
    assign move = is_max_reg ? (cv_reg > pv_reg) : (cv_reg < pv_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        pos_next = pos_reg;
        child_next = child_reg;
        bi_next = bi_reg;
        is_max_next = is_max_reg;
        tie_r_next = tie_r_reg;
        build_next = build_reg;
        val_next = val_reg;
        pv_next = pv_reg;
        cv_next = cv_reg;
        top_next = top_reg;
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        rd_addr = '0;
        we = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = in_data.value;
                    top_next = '0;
                    st_next = ST_DONE;
                    build_next = 1'b0;
                    state_next = S_OUT;
                    case (in_data.func)
                        FN_APPEND, FN_INSERT:
                        begin
                            if (cnt_reg >= CW'(DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else if (in_data.func == FN_APPEND)
                            begin
                                we = 1'b1;
                                wr_addr = cnt_reg[AW-1:0];
                                wr_data = in_data.value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                pos_next = PW'(cnt_reg);
                                cnt_next = cnt_reg + CW'(1);
                                state_next = S_URD;
                            end
                        end
                        FN_XMIN, FN_XMAX:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                // root is read at the accepting edge
                                is_max_next = (in_data.func == FN_XMAX);
                                tie_r_next = 1'b0;
                                cnt_next = cnt_reg - CW'(1);
                                n_next = cnt_reg - CW'(1);
                                state_next = S_DLAST;
                            end
                        end
                        FN_BMIN, FN_BMAX:
                        begin
                            if (cnt_reg >= CW'(2))
                            begin
                                is_max_next = (in_data.func == FN_BMAX);
                                tie_r_next = (in_data.func == FN_BMIN);
                                build_next = 1'b1;
                                n_next = cnt_reg;
                                bi_next = b_start;
                                pos_next = b_start;
                                child_next = b_start * PW'(2) + PW'(1);
                                rd_addr = b_start[AW-1:0];
                                state_next = S_DLOAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // sift up: read parent, or write the value into the root
            S_URD:
            begin
                if (pos_reg == '0)
                begin
                    we = 1'b1;
                    wr_addr = AW'(0);
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr = parent[AW-1:0];
                    state_next = S_UCMP;
                end
            end
            S_UCMP:
            begin
                we = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                if (rd_reg > val_reg)
                begin
                    wr_data = rd_reg;
                    pos_next = parent;
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DLAST:
            begin
                top_next = rd_reg;
                rd_addr = n_reg[AW-1:0];
                pos_next = '0;
                child_next = PW'(1);
                state_next = S_DLOAD;
            end
            // sifted element comes in from the registered read
            S_DLOAD:
            begin
                pv_next = rd_reg;
                state_next = S_DPOS;
            end
            S_DPOS:
            begin
                if (child_reg >= PW'(n_reg))
                begin
                    state_next = S_DEND;
                end
                else
                begin
                    rd_addr = child_reg[AW-1:0];
                    state_next = S_DLEFT;
                end
            end
            S_DLEFT:
            begin
                cv_next = rd_reg;
                if (rgt < PW'(n_reg))
                begin
                    rd_addr = rgt[AW-1:0];
                    state_next = S_DRGT;
                end
                else
                begin
                    state_next = S_DSWP;
                end
            end
            S_DRGT:
            begin
                if (take_r)
                begin
                    child_next = rgt;
                    cv_next = rd_reg;
                end
                state_next = S_DSWP;
            end
            S_DSWP:
            begin
                if (move)
                begin
                    we = 1'b1;
                    wr_addr = pos_reg[AW-1:0];
                    wr_data = cv_reg;
                    pos_next = child_reg;
                    child_next = child_reg * PW'(2) + PW'(1);
                    state_next = S_DPOS;
                end
                else
                begin
                    state_next = S_DEND;
                end
            end
            // sifted element lands in its slot, then the next build node or the result
            S_DEND:
            begin
                we = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = pv_reg;
                if (build_reg && bi_reg != '0)
                begin
                    bi_next = bi_dec;
                    pos_next = bi_dec;
                    child_next = bi_dec * PW'(2) + PW'(1);
                    rd_addr = bi_dec[AW-1:0];
                    state_next = S_DLOAD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.top_value = top_reg;
                    out_next.status = st_reg;
                    out_next.fill_count = FILL_W'(cnt_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        pos_reg <= pos_next;
        child_reg <= child_next;
        bi_reg <= bi_next;
        is_max_reg <= is_max_next;
        tie_r_reg <= tie_r_next;
        build_reg <= build_next;
        val_reg <= val_next;
        pv_reg <= pv_next;
        cv_reg <= cv_next;
        top_reg <= top_next;
        st_reg <= st_next;
        out_reg <= out_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("count above depth");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg != S_IDLE)
        else $error("item not taken");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_fill_rej: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_FULL) |-> out_data.fill_count == FILL_W'(DEPTH))
        else $error("full reject with room");
endmodule

>>> tb/binary_heap_engine_checker.sv
// binary_heap_engine_checker: watches both channels of the heap engine, predicts each result
// from its own copy of the heap and compares field by field; depends on bhe_pkg
module binary_heap_engine_checker #(
    parameter int DEPTH = bhe_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  bhe_pkg::bhe_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  bhe_pkg::bhe_out_t out_data,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bhe_pkg::*;

    logic signed [VALUE_W-1:0] heap_copy [DEPTH];
    int                        heap_fill;
    bhe_out_t                  result_queue [$];

    function automatic bit ranks_above(logic signed [VALUE_W-1:0] a,
                                       logic signed [VALUE_W-1:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic sift_down(int pos, int n, bit is_max, bit tie_right);
        int child;
        logic signed [VALUE_W-1:0] t;
        child = 2 * pos + 1;
        while (child < n) begin
            if (child + 1 < n)
            begin
                if (ranks_above(heap_copy[child+1], heap_copy[child], is_max) ||
                    (tie_right && heap_copy[child+1] == heap_copy[child]))
                    child = child + 1;
            end
            if (ranks_above(heap_copy[child], heap_copy[pos], is_max))
            begin
                t = heap_copy[pos];
                heap_copy[pos] = heap_copy[child];
                heap_copy[child] = t;
                pos = child;
                child = 2 * pos + 1;
            end
            else
                break;
        end
    endtask

    task automatic predict_heap_op(bhe_in_t op);
        bhe_out_t r;
        int pos;
        r = '0;
        r.status = ST_DONE;
        case (op.func)
            FN_APPEND, FN_INSERT:
            begin
                if (heap_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = heap_fill;
                    heap_fill++;
                    if (op.func == FN_INSERT)
                    begin
                        while (pos > 0 && heap_copy[(pos-1)/2] > op.value) begin
                            heap_copy[pos] = heap_copy[(pos-1)/2];
                            pos = (pos - 1) / 2;
                        end
                    end
                    heap_copy[pos] = op.value;
                end
            end
            FN_XMIN, FN_XMAX:
            begin
                if (heap_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.top_value = heap_copy[0];
                    heap_fill--;
                    heap_copy[0] = heap_copy[heap_fill];
                    sift_down(0, heap_fill, op.func == FN_XMAX, 1'b0);
                end
            end
            FN_BMIN, FN_BMAX:
            begin
                if (heap_fill >= 2)
                begin
                    for (int i = (heap_fill - 2) / 2; i >= 0; i--)
                        sift_down(i, heap_fill, op.func == FN_BMAX, op.func == FN_BMIN);
                end
            end
            default: ;
        endcase
        r.fill_count = FILL_W'(heap_fill);
        result_queue.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bhe_out_t want;
        if (!rst_n)
        begin
            heap_fill = 0;
            fail_count <= 0;
            result_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result item %p", out_data);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (out_data.top_value !== want.top_value || out_data.status !== want.status ||
                        out_data.fill_count !== want.fill_count)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: expected top %0d status %0d fill %0d, ",
                                      "got %0d %0d %0d"},
                                     want.top_value, want.status, want.fill_count,
                                     out_data.top_value, out_data.status, out_data.fill_count);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_heap_op(in_data);
        end
        pending_count = result_queue.size();
    end
endmodule

>>> tb/binary_heap_engine_tb.sv
// binary_heap_engine_tb: drives directed and random heap operations into the engine and
// gives the verdict; depends on bhe_pkg, binary_heap_engine and binary_heap_engine_checker
module binary_heap_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bhe_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    bhe_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    bhe_out_t out_data;
    int       fail_count;
    int       pending_count;
    int       idle_cycles;
    bit       no_idle;
    bhe_in_t  op_list [$];

    binary_heap_engine #(.DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    binary_heap_engine_checker #(.DEPTH(DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !no_idle && ($urandom_range(99) < 17);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return VALUE_W'($urandom_range(7)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v);
        bhe_in_t op;
        op.func = f;
        op.value = v;
        op_list.push_back(op);
    endtask

    initial
    begin
        int mode;
        int burst;
        bit quiet;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        no_idle = 1'b0;

        add_op(FN_XMIN, 0);
        add_op(FN_XMAX, 0);
        add_op(FN_BMIN, 0);
        add_op(FN_INSERT, 32'sh7fffffff);
        add_op(FN_BMAX, 0);
        add_op(FN_INSERT, 32'sh80000000);
        add_op(FN_APPEND, -1);
        add_op(FN_APPEND, 5);
        add_op(FN_APPEND, 5);
        add_op(FN_BMIN, 0);
        add_op(FN_BMAX, 0);
        add_op(FN_XMAX, 0);
        add_op(FN_XMIN, 0);
        add_op(FN_SPARE_LO, 7);
        add_op(FN_SPARE_HI, -7);
        for (int i = 0; i < 14; i++)
            add_op(FN_APPEND, i % 3);
        add_op(FN_INSERT, 1);
        add_op(FN_APPEND, 2);
        while (op_list.size() < 830) begin
            mode = $urandom_range(9);
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++) begin
                case (mode)
                    0, 1, 2: add_op(FN_INSERT, pick_value());
                    3, 4:    add_op(FN_APPEND, pick_value());
                    5:       add_op($urandom_range(1) ? FN_XMIN : FN_XMAX, $urandom);
                    6:       add_op(FN_XMIN, $urandom);
                    7:       add_op(FUNC_W'($urandom_range(4, 5)), $urandom);
                    default: add_op(FUNC_W'($urandom_range(7)), pick_value());
                endcase
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < op_list.size(); k++) begin
            quiet = (k >= 300 && k < 450);
            no_idle <= quiet;
            while (!quiet && $urandom_range(99) < 17) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= op_list[k];
            do @(posedge clk); while (in_stall);
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> filelist.f
sv/bhe_pkg.sv
sv/binary_heap_engine.sv
tb/binary_heap_engine_checker.sv
tb/binary_heap_engine_tb.sv
